[rtl/ipv4lpm_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4lpm_pkg
// Types and constants shared by the IPv4 longest-prefix route lookup block.
// ----------------------------------------------------------------------------
package ipv4lpm_pkg;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned LEN_W   = 6;
	localparam int unsigned PEER_W  = 4;
	localparam int unsigned SLOT_W  = 6;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned KIND_W  = 2;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = 1;

	typedef enum logic [KIND_W-1:0] {
		KIND_SLOT_WR = 2'd0,
		KIND_FLAG_WR = 2'd1,
		KIND_LOOKUP  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [SLOT_W-1:0]   slot;
		logic [ADDR_W-1:0]   prefix_addr;
		logic [LEN_W-1:0]    prefix_len;
		logic                slot_valid;
		logic [PEER_W-1:0]   peer;
		logic                exit_capable;
		logic [ADDR_W-1:0]   destination;
		logic                exit_given;
		logic [PEER_W-1:0]   exit_peer;
	} cmd_t;

	typedef struct packed {
		logic                in_use;
		logic [LEN_W-1:0]    len;
		logic [PEER_W-1:0]   owner;
		logic [ADDR_W-1:0]   addr;
	} slot_ent_t;

	// Command queue towards the back end.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmdq_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_LAST
	} st_t;

endpackage

[rtl/ipv4lpm_ram.sv]
// ----------------------------------------------------------------------------
// ipv4lpm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ipv4lpm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/ipv4lpm_front.sv]
// ----------------------------------------------------------------------------
// ipv4lpm_front
// Command intake: takes items, drops reserved kinds and queues the rest.
// ----------------------------------------------------------------------------
module ipv4lpm_front
	import ipv4lpm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [KIND_W-1:0]   kind,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [ADDR_W-1:0]   prefix_addr,
	input  logic [LEN_W-1:0]    prefix_len,
	input  logic                slot_valid,
	input  logic [PEER_W-1:0]   peer,
	input  logic                exit_capable,
	input  logic [ADDR_W-1:0]   destination,
	input  logic                exit_given,
	input  logic [PEER_W-1:0]   exit_peer,
	input  logic                clearing,
	output cmdq_t               q_out,
	input  logic                q_ready
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              accept;
	logic              push;
	logic              pop;
	logic              known_kind;
	cmd_t              new_cmd;

	assign busy   = (count_q == (QPTR_W+1)'(QUEUE_DEPTH)) || clearing;
	assign accept = start && !busy;

	always_comb begin
		case (kind)
			KIND_SLOT_WR, KIND_FLAG_WR, KIND_LOOKUP: known_kind = 1'b1;
			default:                                 known_kind = 1'b0;
		endcase
	end

	always_comb begin
		new_cmd.kind         = kind_t'(kind);
		new_cmd.slot         = slot;
		new_cmd.prefix_addr  = prefix_addr;
		new_cmd.prefix_len   = prefix_len;
		new_cmd.slot_valid   = slot_valid;
		new_cmd.peer         = peer;
		new_cmd.exit_capable = exit_capable;
		new_cmd.destination  = destination;
		new_cmd.exit_given   = exit_given;
		new_cmd.exit_peer    = exit_peer;
	end

	// The reserved kind has no effect at all, so it never enters the queue.
	assign push = accept && known_kind;
	assign pop  = q_out.valid && q_ready;

	assign q_out.valid = (count_q != '0);
	assign q_out.cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/ipv4lpm_back.sv]
// ----------------------------------------------------------------------------
// ipv4lpm_back
// Execution side: slot and flag writes, and the slot-by-slot lookup scan.
// ----------------------------------------------------------------------------
module ipv4lpm_back
	import ipv4lpm_pkg::*;
#(
	parameter int unsigned TABLE_SLOTS = 64,
	parameter int unsigned MAX_PEERS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmdq_t              q_in,
	output logic               q_ready,
	output logic               clearing,
	input  logic [CNT_W-1:0]   peer_count,
	output logic               done,
	output logic               route_found,
	output logic [PEER_W-1:0]  route_peer,
	output logic               via_exit_fallback,
	output logic [LEN_W-1:0]   matched_len
);

	localparam int unsigned SLOT_AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(TABLE_SLOTS - 1);
	localparam int unsigned ENT_W = $bits(slot_ent_t);

	st_t                 state_q;
	st_t                 state_nxt;
	logic [SLOT_AW-1:0]  cnt_q;
	logic                cmp_vld_q;
	logic [MAX_PEERS-1:0] flag_q;

	logic [ADDR_W-1:0]   dest_q;
	logic                exit_given_q;
	logic [PEER_W-1:0]   exit_peer_q;
	logic                found_q;
	logic [PEER_W-1:0]   best_peer_q;
	logic [LEN_W-1:0]    best_len_q;

	logic                ram_we;
	logic [SLOT_AW-1:0]  ram_waddr;
	slot_ent_t           ram_wdata;
	logic [SLOT_AW-1:0]  ram_raddr;
	logic [ENT_W-1:0]    ram_rdata;
	slot_ent_t           ent;

	logic                pop;
	logic                pop_lookup;
	logic                flag_we;
	logic [LEN_W-1:0]    len_c;
	logic [ADDR_W-1:0]   mask;
	logic                owner_ok;
	logic                len_ok;
	logic                hit;
	logic                take;
	logic                found_nxt;
	logic [PEER_W-1:0]   peer_nxt;
	logic [LEN_W-1:0]    len_nxt;
	logic                exit_flag;
	logic                exit_ok;

	ipv4lpm_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ent = slot_ent_t'(ram_rdata);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (cnt_q == LAST_SLOT) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_in.valid && q_in.cmd.kind == KIND_LOOKUP) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == LAST_SLOT) begin
					state_nxt = ST_LAST;
				end
			end
			ST_LAST: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		q_ready   = 1'b0;
		clearing  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		ram_raddr = cnt_q;
		flag_we   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clearing = 1'b1;
				ram_we   = 1'b1;
			end
			ST_IDLE: begin
				q_ready             = 1'b1;
				ram_waddr           = SLOT_AW'(q_in.cmd.slot);
				ram_wdata.in_use    = q_in.cmd.slot_valid;
				ram_wdata.len       = q_in.cmd.prefix_len;
				ram_wdata.owner     = q_in.cmd.peer;
				ram_wdata.addr      = q_in.cmd.prefix_addr;
				ram_we  = q_in.valid && q_in.cmd.kind == KIND_SLOT_WR &&
					(32'(q_in.cmd.slot) < TABLE_SLOTS);
				flag_we = q_in.valid && q_in.cmd.kind == KIND_FLAG_WR;
			end
			default: begin
			end
		endcase
	end

	assign pop        = q_in.valid && q_ready;
	assign pop_lookup = pop && q_in.cmd.kind == KIND_LOOKUP;

	// Comparison of the slot read in the previous cycle. A stored length above
	// 32 behaves as 32; shifting all ones right by the length gives the host
	// part of the address, whose complement is the network mask.
	assign len_c    = (ent.len > MAX_LEN) ? MAX_LEN : ent.len;
	assign mask     = ~({ADDR_W{1'b1}} >> len_c);
	assign owner_ok = (32'(ent.owner) < 32'(peer_count)) && (32'(ent.owner) < MAX_PEERS);
	assign len_ok   = (len_c != '0) || (exit_given_q && exit_peer_q == ent.owner);
	assign hit      = cmp_vld_q && ent.in_use && owner_ok && len_ok &&
		(((dest_q ^ ent.addr) & mask) == '0);
	assign take     = hit && (!found_q || len_c > best_len_q);

	assign found_nxt = found_q || take;
	assign peer_nxt  = take ? ent.owner : best_peer_q;
	assign len_nxt   = take ? len_c : best_len_q;

	always_comb begin
		exit_flag = 1'b0;
		for (int i = 0; i < MAX_PEERS; i++) begin
			if (32'(exit_peer_q) == i) begin
				exit_flag = flag_q[i];
			end
		end
	end

	assign exit_ok = exit_given_q && (32'(exit_peer_q) < 32'(peer_count)) &&
		(32'(exit_peer_q) < MAX_PEERS) && exit_flag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			cmp_vld_q <= 1'b0;
			flag_q    <= '0;
			done      <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			cmp_vld_q <= (state_q == ST_SCAN);
			done      <= (state_q == ST_LAST);
			if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				cnt_q <= (cnt_q == LAST_SLOT) ? '0 : cnt_q + 1'b1;
			end
			if (flag_we) begin
				for (int i = 0; i < MAX_PEERS; i++) begin
					if (32'(q_in.cmd.peer) == i) begin
						flag_q[i] <= q_in.cmd.exit_capable;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_lookup) begin
			dest_q       <= q_in.cmd.destination;
			exit_given_q <= q_in.cmd.exit_given;
			exit_peer_q  <= q_in.cmd.exit_peer;
			found_q      <= 1'b0;
			best_peer_q  <= '0;
			best_len_q   <= '0;
		end else begin
			found_q     <= found_nxt;
			best_peer_q <= peer_nxt;
			best_len_q  <= len_nxt;
		end
		if (state_q == ST_LAST) begin
			if (found_nxt) begin
				route_found       <= 1'b1;
				route_peer        <= peer_nxt;
				via_exit_fallback <= 1'b0;
				matched_len       <= len_nxt;
			end else if (exit_ok) begin
				route_found       <= 1'b1;
				route_peer        <= exit_peer_q;
				via_exit_fallback <= 1'b1;
				matched_len       <= '0;
			end else begin
				route_found       <= 1'b0;
				route_peer        <= '0;
				via_exit_fallback <= 1'b0;
				matched_len       <= '0;
			end
		end
	end

endmodule

[rtl/ipv4_longest_prefix_route_lookup_top.sv]
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_route_lookup_top
// IPv4 longest-prefix route lookup over a table of prefix slots.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low, and wait in a
// two-entry queue until the execution side is free. Slot and exit-flag writes
// give no result. A lookup reads the slot RAM one entry per cycle through its
// single read port, and its result appears for exactly one cycle with done
// high; the receiver cannot stall it. After reset the block marks every slot
// unused and holds busy high meanwhile. The peer count register is written
// through the cfg channel, which is always ready.
module ipv4_longest_prefix_route_lookup_top
	import ipv4lpm_pkg::*;
#(
	parameter int unsigned TABLE_SLOTS = 64,
	parameter int unsigned MAX_PEERS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [KIND_W-1:0]  kind,
	input  logic [SLOT_W-1:0]  slot,
	input  logic [ADDR_W-1:0]  prefix_addr,
	input  logic [LEN_W-1:0]   prefix_len,
	input  logic               slot_valid,
	input  logic [PEER_W-1:0]  peer,
	input  logic               exit_capable,
	input  logic [ADDR_W-1:0]  destination,
	input  logic               exit_given,
	input  logic [PEER_W-1:0]  exit_peer,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CNT_W-1:0]   cfg_data,
	output logic               done,
	output logic               route_found,
	output logic [PEER_W-1:0]  route_peer,
	output logic               via_exit_fallback,
	output logic [LEN_W-1:0]   matched_len
);

	logic [CNT_W-1:0] peer_count_q;
	cmdq_t            cmdq;
	logic             q_ready;
	logic             clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			peer_count_q <= cfg_data;
		end
	end

	ipv4lpm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.slot         (slot),
		.prefix_addr  (prefix_addr),
		.prefix_len   (prefix_len),
		.slot_valid   (slot_valid),
		.peer         (peer),
		.exit_capable (exit_capable),
		.destination  (destination),
		.exit_given   (exit_given),
		.exit_peer    (exit_peer),
		.clearing     (clearing),
		.q_out        (cmdq),
		.q_ready      (q_ready)
	);

	ipv4lpm_back #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.MAX_PEERS   (MAX_PEERS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_in              (cmdq),
		.q_ready           (q_ready),
		.clearing          (clearing),
		.peer_count        (peer_count_q),
		.done              (done),
		.route_found       (route_found),
		.route_peer        (route_peer),
		.via_exit_fallback (via_exit_fallback),
		.matched_len       (matched_len)
	);

endmodule
